// File: rtl/dmf_pkg.sv
// Shared constants and sequencer codes for the dense max-flow engine.
// No dependencies.
package dmf_pkg;
    localparam int VB        = 6;          // vertex index bits
    localparam int NV        = 64;         // max vertices
    localparam int CAP_BITS  = 16;
    localparam int FLOW_BITS = CAP_BITS + 1;
    localparam int RES_BITS  = CAP_BITS + 2;
    localparam int TOT_BITS  = 22;
    localparam int CNT_BITS  = 7;
    localparam int ADDR_BITS = 2 * VB;

    localparam logic [CNT_BITS-1:0] UNREACHED = 7'd127;
    localparam logic [RES_BITS-1:0] BIG_PUSH  = {RES_BITS{1'b1}};

    localparam logic [1:0] REG_VCOUNT = 2'd0;
    localparam logic [1:0] REG_SOURCE = 2'd1;
    localparam logic [1:0] REG_SINK   = 2'd2;

    localparam logic REQ_WRITE   = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    localparam logic [4:0] S_INIT  = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_FCLR  = 5'd2;
    localparam logic [4:0] S_LINIT = 5'd3;
    localparam logic [4:0] S_LSRC  = 5'd4;
    localparam logic [4:0] S_BPOP  = 5'd5;
    localparam logic [4:0] S_BU1   = 5'd6;
    localparam logic [4:0] S_BU2   = 5'd7;
    localparam logic [4:0] S_BV1   = 5'd8;
    localparam logic [4:0] S_BV2   = 5'd9;
    localparam logic [4:0] S_LCHK  = 5'd10;
    localparam logic [4:0] S_LCHK2 = 5'd11;
    localparam logic [4:0] S_AINIT = 5'd12;
    localparam logic [4:0] S_A     = 5'd13;
    localparam logic [4:0] S_AP    = 5'd14;
    localparam logic [4:0] S_AE    = 5'd15;
    localparam logic [4:0] S_APOP  = 5'd16;
    localparam logic [4:0] S_APOP2 = 5'd17;
    localparam logic [4:0] S_AK1   = 5'd18;
    localparam logic [4:0] S_AK2   = 5'd19;
    localparam logic [4:0] S_AK3   = 5'd20;
    localparam logic [4:0] S_AK4   = 5'd21;
    localparam logic [4:0] S_AK5   = 5'd22;
    localparam logic [4:0] S_OUT   = 5'd23;
endpackage

// File: rtl/dinic_max_flow_dense.sv
// Dense max-flow engine, Dinic's method over a 64x64 capacity matrix.
// Depends on dmf_pkg.
//
// Input channel (in_valid/in_stall): req_type 0 writes one edge capacity and
// gives no result; req_type 1 runs max flow from source_vertex to
// sink_vertex over vertices 0..n-1, n being vertex_count clamped to 2..64.
// Output channel (out_valid/out_stall): one beat per compute item with
// total_flow and phase_count. The result sits in an output register; a
// stalled beat holds, and a later compute waits for it before finishing.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 vertex_count,
// 1 source_vertex, 2 sink_vertex; write only while idle.
// Compute: a compute clears the flow matrix, then per phase initialises
// the levels and edge pointers, runs the level pass over the queued
// vertices, and augments by pointer steps, pushes, retreats and path
// edges. All of it goes through one residual unit that reads one matrix
// entry per cycle.
// Reset: a clearing pass zeroes the capacity matrix, with in_stall high
// meanwhile; registers go to 64 / 0 / 1.
module dinic_max_flow_dense (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [6:0]                cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      req_type,
    input  logic [dmf_pkg::VB-1:0]    edge_from,
    input  logic [dmf_pkg::VB-1:0]    edge_to,
    input  logic [15:0]               edge_capacity,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [dmf_pkg::TOT_BITS-1:0] total_flow,
    output logic [6:0]                phase_count
);
    import dmf_pkg::*;

    logic [4:0]          state_reg, state_next;
    logic [ADDR_BITS:0]  cnt_reg, cnt_next;
    logic [CNT_BITS-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [VB-1:0]       u_reg, u_next;
    logic [CNT_BITS-1:0] lu_reg, lu_next, v_reg, v_next;
    logic [CNT_BITS-1:0] depth_reg, depth_next, k_reg, k_next;
    logic [VB-1:0]       cur_u_reg, cur_u_next;
    logic [RES_BITS-1:0] cur_b_reg, cur_b_next;
    logic [VB-1:0]       a_reg, a_next, b_reg, b_next;
    logic [TOT_BITS-1:0] total_reg, total_next;
    logic [6:0]          phase_reg, phase_next;
    logic                out_valid_reg, out_valid_next;
    logic [TOT_BITS-1:0] out_total_reg, out_total_next;
    logic [6:0]          out_phase_reg, out_phase_next;
    logic [6:0]          vc_reg;
    logic [VB-1:0]       src_reg, snk_reg;

    logic [CAP_BITS-1:0]  cap_mem [0:NV*NV-1];
    logic [FLOW_BITS-1:0] fl_mem [0:NV*NV-1];
    logic [CNT_BITS-1:0]  lvl_mem [0:NV-1];
    logic [CNT_BITS-1:0]  ep_mem [0:NV-1];
    logic [VB-1:0]        q_mem [0:NV-1];
    logic [VB-1:0]        ps_mem [0:NV];
    logic [RES_BITS-1:0]  bs_mem [0:NV];

    logic                 cap_we, fl_we, lvl_we, ep_we, q_we, ps_we, bs_we;
    logic [ADDR_BITS-1:0] cap_wa, cap_ra, fl_wa, fl_ra;
    logic [CAP_BITS-1:0]  cap_wd, cap_rd;
    logic [FLOW_BITS-1:0] fl_wd, fl_rd;
    logic [VB-1:0]        lvl_wa, lvl_ra, ep_wa, ep_ra, q_wa, q_ra, q_wd, q_rd;
    logic [CNT_BITS-1:0]  lvl_wd, lvl_rd, ep_wd, ep_rd;
    logic [CNT_BITS-1:0]  ps_wa, ps_ra, bs_wa, bs_ra;
    logic [VB-1:0]        ps_wd, ps_rd;
    logic [RES_BITS-1:0]  bs_wd, bs_rd;

    logic [6:0]          n_eff;
    logic [RES_BITS-1:0] res;
    logic                res_pos;
    logic [RES_BITS-1:0] res_min;
    logic                run_ok;

    assign n_eff   = (vc_reg < 7'd2) ? 7'd2 : ((vc_reg > 7'd64) ? 7'd64 : vc_reg);
    assign res     = {2'b00, cap_rd} - {fl_rd[FLOW_BITS-1], fl_rd};
    assign res_pos = !res[RES_BITS-1] && (res != '0);
    assign res_min = (res < cur_b_reg) ? res : cur_b_reg;
    assign run_ok  = (src_reg != snk_reg) && ({1'b0, src_reg} < n_eff)
                     && ({1'b0, snk_reg} < n_eff);

    assign cfg_ready   = 1'b1;
    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign total_flow  = out_total_reg;
    assign phase_count = out_phase_reg;

    always_ff @(posedge clk)
    begin
        if (cap_we) cap_mem[cap_wa] <= cap_wd;
        cap_rd <= cap_mem[cap_ra];
        if (fl_we) fl_mem[fl_wa] <= fl_wd;
        fl_rd <= fl_mem[fl_ra];
        if (lvl_we) lvl_mem[lvl_wa] <= lvl_wd;
        lvl_rd <= lvl_mem[lvl_ra];
        if (ep_we) ep_mem[ep_wa] <= ep_wd;
        ep_rd <= ep_mem[ep_ra];
        if (q_we) q_mem[q_wa] <= q_wd;
        q_rd <= q_mem[q_ra];
        if (ps_we) ps_mem[ps_wa] <= ps_wd;
        ps_rd <= ps_mem[ps_ra];
        if (bs_we) bs_mem[bs_wa] <= bs_wd;
        bs_rd <= bs_mem[bs_ra];
    end

    always_comb
    begin
        state_next = state_reg;  cnt_next = cnt_reg;
        head_next = head_reg;    tail_next = tail_reg;
        u_next = u_reg;          lu_next = lu_reg;      v_next = v_reg;
        depth_next = depth_reg;  k_next = k_reg;
        cur_u_next = cur_u_reg;  cur_b_next = cur_b_reg;
        a_next = a_reg;          b_next = b_reg;
        total_next = total_reg;  phase_next = phase_reg;
        out_total_next = out_total_reg;  out_phase_next = out_phase_reg;
        out_valid_next = out_valid_reg && out_stall;
        cap_we = 1'b0; cap_wa = '0; cap_wd = '0; cap_ra = '0;
        fl_we = 1'b0;  fl_wa = '0;  fl_wd = '0;  fl_ra = '0;
        lvl_we = 1'b0; lvl_wa = '0; lvl_wd = '0; lvl_ra = '0;
        ep_we = 1'b0;  ep_wa = '0;  ep_wd = '0;  ep_ra = '0;
        q_we = 1'b0;   q_wa = '0;   q_wd = '0;   q_ra = '0;
        ps_we = 1'b0;  ps_wa = '0;  ps_wd = '0;  ps_ra = '0;
        bs_we = 1'b0;  bs_wa = '0;  bs_wd = '0;  bs_ra = '0;
        case (state_reg)
            S_INIT:
            begin
                cap_we = 1'b1;
                cap_wa = cnt_reg[ADDR_BITS-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[ADDR_BITS-1:0] == {ADDR_BITS{1'b1}})
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == REQ_WRITE)
                    begin
                        cap_we = 1'b1;
                        cap_wa = {edge_from, edge_to};
                        cap_wd = edge_capacity[CAP_BITS-1:0];
                    end
                    else
                    begin
                        cnt_next = '0;
                        total_next = '0;
                        phase_next = '0;
                        state_next = S_FCLR;
                    end
                end
            end
            S_FCLR:
            begin
                fl_we = 1'b1;
                fl_wa = cnt_reg[ADDR_BITS-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[ADDR_BITS-1:0] == {ADDR_BITS{1'b1}})
                begin
                    cnt_next = '0;
                    state_next = run_ok ? S_LINIT : S_OUT;
                end
            end
            S_LINIT:
            begin
                lvl_we = 1'b1; lvl_wa = cnt_reg[VB-1:0]; lvl_wd = UNREACHED;
                ep_we = 1'b1;  ep_wa = cnt_reg[VB-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[VB-1:0] == {VB{1'b1}})
                    state_next = S_LSRC;
            end
            S_LSRC:
            begin
                lvl_we = 1'b1; lvl_wa = src_reg;
                q_we = 1'b1;   q_wd = src_reg;
                head_next = '0;
                tail_next = 7'd1;
                state_next = S_BPOP;
            end
            S_BPOP:
            begin
                q_ra = head_reg[VB-1:0];
                lvl_ra = snk_reg;
                state_next = (head_reg < tail_reg) ? S_BU1 : S_LCHK2;
            end
            S_BU1:
            begin
                u_next = q_rd;
                head_next = head_reg + 1'b1;
                lvl_ra = q_rd;
                state_next = S_BU2;
            end
            S_BU2:
            begin
                lu_next = lvl_rd;
                v_next = '0;
                state_next = S_BV1;
            end
            S_BV1:
            begin
                lvl_ra = v_reg[VB-1:0];
                cap_ra = {u_reg, v_reg[VB-1:0]};
                fl_ra  = {u_reg, v_reg[VB-1:0]};
                state_next = (v_reg < n_eff) ? S_BV2 : S_BPOP;
            end
            S_BV2:
            begin
                if (lvl_rd == UNREACHED && res_pos)
                begin
                    lvl_we = 1'b1; lvl_wa = v_reg[VB-1:0]; lvl_wd = lu_reg + 1'b1;
                    if (tail_reg < 7'd64)
                    begin
                        q_we = 1'b1; q_wa = tail_reg[VB-1:0]; q_wd = v_reg[VB-1:0];
                        tail_next = tail_reg + 1'b1;
                    end
                end
                v_next = v_reg + 1'b1;
                state_next = S_BV1;
            end
            S_LCHK:
            begin
                lvl_ra = snk_reg;
                state_next = S_LCHK2;
            end
            S_LCHK2:
            begin
                if (lvl_rd != UNREACHED)
                begin
                    phase_next = phase_reg + 1'b1;
                    state_next = S_AINIT;
                end
                else
                    state_next = S_OUT;
            end
            S_AINIT:
            begin
                ps_we = 1'b1; ps_wd = src_reg;
                bs_we = 1'b1; bs_wd = BIG_PUSH;
                depth_next = '0;
                cur_u_next = src_reg;
                cur_b_next = BIG_PUSH;
                state_next = S_A;
            end
            S_A:
            begin
                ep_ra = cur_u_reg;
                lvl_ra = cur_u_reg;
                if (cur_u_reg == snk_reg)
                begin
                    k_next = '0;
                    state_next = S_AK1;
                end
                else
                    state_next = S_AP;
            end
            S_AP:
            begin
                v_next = ep_rd;
                lu_next = lvl_rd;
                lvl_ra = ep_rd[VB-1:0];
                cap_ra = {cur_u_reg, ep_rd[VB-1:0]};
                fl_ra  = {cur_u_reg, ep_rd[VB-1:0]};
                ps_ra = depth_reg - 1'b1;
                bs_ra = depth_reg - 1'b1;
                if (ep_rd < n_eff)
                    state_next = S_AE;
                else if (depth_reg == '0)
                begin
                    cnt_next = '0;
                    state_next = S_LINIT;
                end
                else
                begin
                    depth_next = depth_reg - 1'b1;
                    state_next = S_APOP;
                end
            end
            S_AE:
            begin
                if (res_pos && lvl_rd == lu_reg + 1'b1 && depth_reg < 7'd64)
                begin
                    depth_next = depth_reg + 1'b1;
                    ps_we = 1'b1; ps_wa = depth_reg + 1'b1; ps_wd = v_reg[VB-1:0];
                    bs_we = 1'b1; bs_wa = depth_reg + 1'b1; bs_wd = res_min;
                    cur_u_next = v_reg[VB-1:0];
                    cur_b_next = res_min;
                end
                else
                begin
                    ep_we = 1'b1; ep_wa = cur_u_reg; ep_wd = v_reg + 1'b1;
                end
                state_next = S_A;
            end
            S_APOP:
            begin
                cur_u_next = ps_rd;
                cur_b_next = bs_rd;
                ep_ra = ps_rd;
                state_next = S_APOP2;
            end
            S_APOP2:
            begin
                ep_we = 1'b1; ep_wa = cur_u_reg; ep_wd = ep_rd + 1'b1;
                state_next = S_A;
            end
            S_AK1:
            begin
                ps_ra = k_reg;
                if (k_reg < depth_reg)
                    state_next = S_AK2;
                else
                begin
                    total_next = total_reg + {{(TOT_BITS-RES_BITS){1'b0}}, cur_b_reg};
                    depth_next = '0;
                    cur_u_next = src_reg;
                    cur_b_next = BIG_PUSH;
                    state_next = S_A;
                end
            end
            S_AK2:
            begin
                a_next = ps_rd;
                ps_ra = k_reg + 1'b1;
                state_next = S_AK3;
            end
            S_AK3:
            begin
                b_next = ps_rd;
                fl_ra = {a_reg, ps_rd};
                state_next = S_AK4;
            end
            S_AK4:
            begin
                fl_we = 1'b1; fl_wa = {a_reg, b_reg};
                fl_wd = fl_rd + cur_b_reg[FLOW_BITS-1:0];
                fl_ra = {b_reg, a_reg};
                state_next = S_AK5;
            end
            S_AK5:
            begin
                fl_we = 1'b1; fl_wa = {b_reg, a_reg};
                fl_wd = fl_rd - cur_b_reg[FLOW_BITS-1:0];
                k_next = k_reg + 1'b1;
                state_next = S_AK1;
            end
            S_OUT:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_total_next = total_reg;
                    out_phase_next = phase_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            vc_reg <= 7'd64;
            src_reg <= '0;
            snk_reg <= 6'd1;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_VCOUNT: vc_reg <= cfg_data;
                    REG_SOURCE: src_reg <= cfg_data[VB-1:0];
                    REG_SINK:   snk_reg <= cfg_data[VB-1:0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;   tail_reg <= tail_next;
        u_reg <= u_next;         lu_reg <= lu_next;     v_reg <= v_next;
        depth_reg <= depth_next; k_reg <= k_next;
        cur_u_reg <= cur_u_next; cur_b_reg <= cur_b_next;
        a_reg <= a_next;         b_reg <= b_next;
        total_reg <= total_next; phase_reg <= phase_next;
        out_total_reg <= out_total_next;
        out_phase_reg <= out_phase_next;
    end
endmodule

// File: rtl/dmf_checker.sv
// Port-level checks for the dense max-flow engine, bound to the top level.
// Depends on dmf_pkg and dinic_max_flow_dense.
module dmf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          req_type,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [dmf_pkg::TOT_BITS-1:0]  total_flow,
    input logic [6:0]                    phase_count
);
    import dmf_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(total_flow))
        else $error("stalled result beat changed");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && req_type == REQ_COMPUTE |=> in_stall)
        else $error("compute beat did not make the block busy");

    a_no_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && phase_count == 7'd0 |-> total_flow == '0)
        else $error("flow without any phase");

    a_phase_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> phase_count <= 7'd64)
        else $error("phase count out of range");
endmodule

bind dinic_max_flow_dense dmf_checker u_dmf_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .out_valid(out_valid), .out_stall(out_stall),
    .total_flow(total_flow), .phase_count(phase_count)
);
